### rtl/core/dop_pkg.sv
// Shared constants and the parsed-event type for the DHCP options parser.
package dop_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CODE_PAD  = 8'h00;
    localparam logic [7:0] CODE_END  = 8'hff;
    localparam logic [7:0] CODE_TYPE = 8'd53;
    localparam logic [7:0] CODE_ADDR = 8'd50;
    localparam logic [7:0] CODE_NAME = 8'd12;
    localparam logic [7:0] TYPE_MIN  = 8'd1;
    localparam logic [7:0] TYPE_MAX  = 8'd8;

    // Value index saturates here; only the first four value bytes matter.
    localparam logic [2:0] IDX_SAT   = 3'd4;
    localparam logic [2:0] IDX_ADDR4 = 3'd3;

    localparam logic KIND_NAME    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // What one options byte produced: an optional hostname byte and an
    // optional packet summary.
    typedef struct packed {
        logic        name_vld;
        logic [7:0]  name_byte;
        logic        name_start;
        logic        sum_vld;
        logic [3:0]  msg_type;
        logic [31:0] addr;
        logic        status;
    } event_t;

endpackage

### rtl/core/dhcp_option_parser_top.sv
// Top level of the DHCP options parser: front end, event queue, back end.
//
// Input channel: the options area arrives one byte per item with push/full.
// first_byte starts a packet and samples client_addr; last_byte closes it.
// Result channel: empty/pop. A byte inside option 12 gives a hostname item
// (kind 0); the end code, an invalid message type or the last byte gives a
// summary item (kind 1) with the type, requested address and status.
// run_end marks the last item caused by one input byte.
// A result passes through the event queue and then the output register
// on its way to the ports.
// Throughput: one byte per cycle while full is low; the back end delivers
// one item per cycle while pop is high, so a byte yielding both a hostname
// item and a summary falls behind, absorbed by the QueueDepth-entry event queue.
// When the receiver stalls, the queue fills and full rises; nothing is lost.
// Reset empties the queue and the output register and returns the parser
// to expecting an option code with a client address of zero.
module dhcp_option_parser_top #(
    parameter int QueueDepth = dop_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    input  logic [31:0] client_addr,
    output logic        empty,
    input  logic        pop,
    output logic        kind,
    output logic [7:0]  name_byte,
    output logic        name_start,
    output logic [3:0]  dhcp_type,
    output logic [31:0] wanted_addr,
    output logic        status,
    output logic        run_end
);

    logic            accept;
    logic            ev_vld;
    dop_pkg::event_t ev;
    logic            q_full;
    logic            q_vld;
    dop_pkg::event_t q_data;
    logic            q_pop;

    assign full   = q_full;
    assign accept = push && !q_full;

    dop_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (data_byte),
        .first_byte  (first_byte),
        .last_byte   (last_byte),
        .client_addr (client_addr),
        .ev_vld      (ev_vld),
        .ev          (ev)
    );

    dop_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (ev_vld),
        .wr_data (ev),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_vld  (q_vld),
        .rd_data (q_data)
    );

    dop_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .ev_vld       (q_vld),
        .ev           (q_data),
        .ev_pop       (q_pop),
        .pop          (pop),
        .empty        (empty),
        .kind         (kind),
        .name_byte    (name_byte),
        .name_start   (name_start),
        .dhcp_type    (dhcp_type),
        .wanted_addr  (wanted_addr),
        .status       (status),
        .run_end      (run_end)
    );

endmodule

### rtl/core/dop_front.sv
// Front end: walks the option records one byte per cycle while accept is high and emits events.
module dop_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic [7:0]     data_byte,
    input  logic           first_byte,
    input  logic           last_byte,
    input  logic [31:0]    client_addr,
    output logic           ev_vld,
    output dop_pkg::event_t ev
);

    typedef enum logic [1:0] {PH_CODE, PH_LEN, PH_VALUE, PH_DONE} phase_t;

    phase_t      phase_reg, phase_next, phase_cur;
    logic [7:0]  code_reg, code_next, code_cur;
    logic [7:0]  left_reg, left_next, left_cur;
    logic [2:0]  idx_reg, idx_next, idx_cur;
    logic [3:0]  type_reg, type_next, type_cur;
    logic [31:0] addr_reg, addr_next, addr_cur;
    logic [23:0] shift_reg, shift_next, shift_cur;
    logic        status_reg, status_next, status_cur;
    logic        stop;
    logic        name_hit;

    // A first byte restarts the packet before the byte itself is parsed.
    always_comb
    begin
        phase_cur  = first_byte ? PH_CODE : phase_reg;
        code_cur   = first_byte ? 8'd0 : code_reg;
        left_cur   = first_byte ? 8'd0 : left_reg;
        idx_cur    = first_byte ? 3'd0 : idx_reg;
        type_cur   = first_byte ? 4'd0 : type_reg;
        addr_cur   = first_byte ? client_addr : addr_reg;
        shift_cur  = first_byte ? 24'd0 : shift_reg;
        status_cur = first_byte ? 1'b0 : status_reg;
    end

    always_comb
    begin
        phase_next  = phase_cur;
        code_next   = code_cur;
        left_next   = left_cur;
        idx_next    = idx_cur;
        type_next   = type_cur;
        addr_next   = addr_cur;
        shift_next  = shift_cur;
        status_next = status_cur;
        stop        = 1'b0;
        name_hit    = 1'b0;
        case (phase_cur)
            PH_CODE:
            begin
                if (data_byte == dop_pkg::CODE_END)
                begin
                    stop = 1'b1;
                end
                else if (data_byte != dop_pkg::CODE_PAD)
                begin
                    code_next  = data_byte;
                    phase_next = PH_LEN;
                end
            end
            PH_LEN:
            begin
                left_next  = data_byte;
                idx_next   = 3'd0;
                shift_next = 24'd0;
                phase_next = (data_byte != 8'd0) ? PH_VALUE : PH_CODE;
            end
            PH_VALUE:
            begin
                if (code_cur == dop_pkg::CODE_TYPE && idx_cur == 3'd0)
                begin
                    if (data_byte inside {[dop_pkg::TYPE_MIN:dop_pkg::TYPE_MAX]})
                    begin
                        type_next = data_byte[3:0];
                    end
                    else
                    begin
                        status_next = 1'b1;
                        type_next   = 4'd0;
                        stop        = 1'b1;
                    end
                end
                else if (code_cur == dop_pkg::CODE_ADDR && idx_cur < dop_pkg::IDX_SAT)
                begin
                    shift_next = {shift_cur[15:0], data_byte};
                    if (idx_cur == dop_pkg::IDX_ADDR4)
                    begin
                        addr_next = {shift_cur, data_byte};
                    end
                end
                else if (code_cur == dop_pkg::CODE_NAME)
                begin
                    name_hit = 1'b1;
                end
                if (idx_cur != dop_pkg::IDX_SAT)
                begin
                    idx_next = idx_cur + 3'd1;
                end
                left_next = left_cur - 8'd1;
                if (left_next == 8'd0)
                begin
                    phase_next = PH_CODE;
                end
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase
        if (phase_cur != PH_DONE && last_byte)
        begin
            stop = 1'b1;
        end
        if (stop)
        begin
            phase_next = PH_DONE;
        end
    end

    always_comb
    begin
        ev.name_vld   = name_hit;
        ev.name_byte  = data_byte;
        ev.name_start = (idx_cur == 3'd0);
        ev.sum_vld    = stop;
        ev.msg_type   = type_next;
        ev.addr       = addr_next;
        ev.status     = status_next;
        ev_vld        = accept && (name_hit || stop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_CODE;
            code_reg   <= 8'd0;
            left_reg   <= 8'd0;
            idx_reg    <= 3'd0;
            type_reg   <= 4'd0;
            addr_reg   <= 32'd0;
            shift_reg  <= 24'd0;
            status_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            code_reg   <= code_next;
            left_reg   <= left_next;
            idx_reg    <= idx_next;
            type_reg   <= type_next;
            addr_reg   <= addr_next;
            shift_reg  <= shift_next;
            status_reg <= status_next;
        end
    end

`ifndef SYNTHESIS
    // A stopped packet stays silent until the next first byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_DONE && !first_byte) |-> !ev_vld)
        else $error("event produced after parsing stopped");
    // An invalid message type always reports with type zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ev_vld && ev.status) |-> (ev.sum_vld && ev.msg_type == 4'd0))
        else $error("bad status without a clean summary");
`endif

endmodule

### rtl/core/dop_queue.sv
// Short event queue between the parsing front end and the result back end.
module dop_queue #(
    parameter int Depth = dop_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  dop_pkg::event_t wr_data,
    output logic            full,
    input  logic            rd_en,
    output logic            rd_vld,
    output dop_pkg::event_t rd_data
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(Depth);

    dop_pkg::event_t slots_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_wr, do_rd;

    assign full    = (count_reg == CntFull);
    assign rd_vld  = (count_reg != '0);
    assign rd_data = slots_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && rd_vld;

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CntW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + PtrW'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + PtrW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CntFull)
        else $error("queue count above depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> (count_reg == $past(count_reg) + CntW'(1)))
        else $error("queue count lost a write");
`endif

endmodule

### rtl/core/dop_back.sv
// Back end: turns each queued event into one or two result items.
module dop_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            ev_vld,
    input  dop_pkg::event_t ev,
    output logic            ev_pop,
    input  logic            pop,
    output logic            empty,
    output logic            kind,
    output logic [7:0]      name_byte,
    output logic            name_start,
    output logic [3:0]      dhcp_type,
    output logic [31:0]     wanted_addr,
    output logic            status,
    output logic            run_end
);

    logic        out_vld_reg, out_vld_next;
    logic        name_sent_reg, name_sent_next;
    logic        load;
    logic        load_name;
    logic        kind_reg;
    logic [7:0]  name_byte_reg;
    logic        name_start_reg;
    logic [3:0]  type_reg;
    logic [31:0] addr_reg;
    logic        status_reg;
    logic        run_end_reg;

    // The output register refills in the cycle it is taken.
    assign load      = ev_vld && (!out_vld_reg || pop);
    assign load_name = ev.name_vld && !name_sent_reg;

    always_comb
    begin
        out_vld_next   = out_vld_reg;
        name_sent_next = name_sent_reg;
        ev_pop         = 1'b0;
        if (pop && out_vld_reg)
        begin
            out_vld_next = 1'b0;
        end
        if (load)
        begin
            out_vld_next = 1'b1;
            if (load_name && ev.sum_vld)
            begin
                name_sent_next = 1'b1;
            end
            else
            begin
                name_sent_next = 1'b0;
                ev_pop         = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg   <= 1'b0;
            name_sent_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg   <= out_vld_next;
            name_sent_reg <= name_sent_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (load_name)
            begin
                kind_reg       <= dop_pkg::KIND_NAME;
                name_byte_reg  <= ev.name_byte;
                name_start_reg <= ev.name_start;
                type_reg       <= 4'd0;
                addr_reg       <= 32'd0;
                status_reg     <= 1'b0;
                run_end_reg    <= !ev.sum_vld;
            end
            else
            begin
                kind_reg       <= dop_pkg::KIND_SUMMARY;
                name_byte_reg  <= 8'd0;
                name_start_reg <= 1'b0;
                type_reg       <= ev.msg_type;
                addr_reg       <= ev.addr;
                status_reg     <= ev.status;
                run_end_reg    <= 1'b1;
            end
        end
    end

    assign empty        = !out_vld_reg;
    assign kind         = kind_reg;
    assign name_byte    = name_byte_reg;
    assign name_start   = name_start_reg;
    assign dhcp_type    = type_reg;
    assign wanted_addr  = addr_reg;
    assign status       = status_reg;
    assign run_end      = run_end_reg;

`ifndef SYNTHESIS
    // A half-delivered event must still sit at the queue head.
    assert property (@(posedge clk) disable iff (!rst_n) name_sent_reg |-> ev_vld)
        else $error("summary owed but queue head is gone");
    // A hostname item with a summary still owed is not marked as the run end.
    assert property (@(posedge clk) disable iff (!rst_n)
        (load && load_name && ev.sum_vld) |=> (out_vld_reg && !run_end_reg))
        else $error("hostname item before a summary marked as run end");
`endif

endmodule

### tb/tb_dhcp_option_parser_top.sv
// Testbench for the DHCP options parser: byte stream in, hostname and summary items checked.
module tb_dhcp_option_parser_top;

    localparam int RANDOM_BYTES = 1950;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 80;
    localparam int MAX_PRINTS   = 100;

    typedef enum logic [1:0] {WANT_CODE, WANT_LEN, IN_VALUE, STOPPED} parse_phase_t;

    typedef struct {
        logic [7:0]  data;
        logic        first;
        logic        last;
        logic [31:0] addr;
    } options_byte_t;

    typedef struct {
        logic        kind;
        logic [7:0]  name_byte;
        logic        name_start;
        logic [3:0]  dhcp_type;
        logic [31:0] wanted_addr;
        logic        status;
        logic        run_end;
    } parse_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  data_byte = '0;
    logic        first_byte = 1'b0;
    logic        last_byte = 1'b0;
    logic [31:0] client_addr = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic        kind;
    logic [7:0]  name_byte;
    logic        name_start;
    logic [3:0]  dhcp_type;
    logic [31:0] wanted_addr;
    logic        status;
    logic        run_end;

    options_byte_t pending_bytes [$];
    parse_result_t expected_results [$];
    options_byte_t offered;
    bit            byte_taken = 1'b0;
    int            bytes_taken = 0;
    int            third_len = 0;
    int            errors = 0;
    int            quiet_cycles = 0;
    int            hold_left = 0;
    bit            hold_done = 1'b0;
    int            random_count = 0;

    // Parser state as the block should hold it.
    parse_phase_t  pr_phase = WANT_CODE;
    logic [7:0]    pr_code = '0;
    logic [7:0]    pr_left = '0;
    logic [7:0]    pr_index = '0;
    logic [3:0]    pr_type = '0;
    logic [31:0]   pr_addr = '0;
    logic [31:0]   pr_shift = '0;
    logic          pr_status = 1'b0;

    dhcp_option_parser_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .data_byte    (data_byte),
        .first_byte   (first_byte),
        .last_byte    (last_byte),
        .client_addr  (client_addr),
        .empty        (empty),
        .pop          (pop),
        .kind         (kind),
        .name_byte    (name_byte),
        .name_start   (name_start),
        .dhcp_type    (dhcp_type),
        .wanted_addr  (wanted_addr),
        .status       (status),
        .run_end      (run_end)
    );

    always #2 clk = ~clk;

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= MAX_PRINTS)
        begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    // Sender and receiver take turns idling often, then neither idles.
    function automatic int idle_percent(input bit receiver_side);
        if (bytes_taken >= 2 * third_len)
        begin
            return 0;
        end
        if ((bytes_taken < third_len) == receiver_side)
        begin
            return 75;
        end
        return 9;
    endfunction

    // Walks one options byte through the option records and queues the items it yields.
    task automatic predict_options_byte(input options_byte_t it);
        parse_result_t found [$];
        parse_result_t r;
        bit            stop;
        bit            active;
        stop = 1'b0;
        if (it.first)
        begin
            pr_phase  = WANT_CODE;
            pr_code   = '0;
            pr_left   = '0;
            pr_index  = '0;
            pr_type   = '0;
            pr_addr   = it.addr;
            pr_shift  = '0;
            pr_status = 1'b0;
        end
        active = (pr_phase != STOPPED);
        case (pr_phase)
            WANT_CODE:
            begin
                if (it.data == dop_pkg::CODE_END)
                begin
                    stop = 1'b1;
                end
                else if (it.data != dop_pkg::CODE_PAD)
                begin
                    pr_code  = it.data;
                    pr_phase = WANT_LEN;
                end
            end
            WANT_LEN:
            begin
                pr_left  = it.data;
                pr_index = '0;
                pr_shift = '0;
                if (it.data != 8'd0)
                begin
                    pr_phase = IN_VALUE;
                end
                else
                begin
                    pr_phase = WANT_CODE;
                end
            end
            IN_VALUE:
            begin
                if (pr_code == dop_pkg::CODE_TYPE && pr_index == 8'd0)
                begin
                    if (it.data < dop_pkg::TYPE_MIN || it.data > dop_pkg::TYPE_MAX)
                    begin
                        pr_status = 1'b1;
                        pr_type   = '0;
                        stop      = 1'b1;
                    end
                    else
                    begin
                        pr_type = it.data[3:0];
                    end
                end
                else if (pr_code == dop_pkg::CODE_ADDR && pr_index < 8'd4)
                begin
                    pr_shift = {pr_shift[23:0], it.data};
                    if (pr_index == 8'd3)
                    begin
                        pr_addr = pr_shift;
                    end
                end
                else if (pr_code == dop_pkg::CODE_NAME)
                begin
                    r = '{kind: dop_pkg::KIND_NAME, name_byte: it.data,
                          name_start: (pr_index == 8'd0),
                          dhcp_type: 4'd0, wanted_addr: 32'd0, status: 1'b0, run_end: 1'b0};
                    found.insert(found.size(), r);
                end
                if (pr_index != 8'hff)
                begin
                    pr_index = pr_index + 8'd1;
                end
                pr_left = pr_left - 8'd1;
                if (pr_left == 8'd0)
                begin
                    pr_phase = WANT_CODE;
                end
            end
            default:
            begin
            end
        endcase
        if (active && it.last)
        begin
            stop = 1'b1;
        end
        if (stop)
        begin
            pr_phase = STOPPED;
            r = '{kind: dop_pkg::KIND_SUMMARY, name_byte: 8'd0, name_start: 1'b0,
                  dhcp_type: pr_type, wanted_addr: pr_addr, status: pr_status, run_end: 1'b0};
            found.insert(found.size(), r);
        end
        if (found.size() > 0)
        begin
            found[found.size() - 1].run_end = 1'b1;
        end
        foreach (found[i])
        begin
            expected_results.insert(expected_results.size(), found[i]);
        end
    endtask

    task automatic add_byte(input logic [7:0] d, input logic f, input logic l,
                            input logic [31:0] a);
        options_byte_t it;
        it = '{data: d, first: f, last: l, addr: a};
        pending_bytes.insert(pending_bytes.size(), it);
    endtask

    // Mostly well-formed packets with random content; the rest is noise.
    task automatic queue_random_packet();
        logic [7:0]  body [$];
        logic [31:0] addr;
        int          n_opts;
        int          pick;
        int          len;
        int          cut;
        int          ending;
        int          garbage;
        bit          closed;
        addr = $urandom();
        if ($urandom_range(0, 99) < 15)
        begin
            len = $urandom_range(1, 8);
            repeat (len)
            begin
                add_byte(8'($urandom()), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                         $urandom());
            end
            random_count += len;
            return;
        end
        n_opts = $urandom_range(0, 6);
        repeat (n_opts)
        begin
            pick = $urandom_range(0, 199);
            if (pick == 0)
            begin
                // A rare long option exercises lengths from 100 up to 255.
                body.insert(body.size(), 8'($urandom_range(1, 254)));
                len = $urandom_range(100, 255);
                body.insert(body.size(), 8'(len));
                repeat (len) body.insert(body.size(), 8'($urandom()));
            end
            else
            begin
                case (pick % 6)
                    0: body.insert(body.size(), dop_pkg::CODE_PAD);
                    1:
                    begin
                        body.insert(body.size(), dop_pkg::CODE_TYPE);
                        len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : 1;
                        body.insert(body.size(), 8'(len));
                        repeat (len)
                        begin
                            if ($urandom_range(0, 9) == 0)
                            begin
                                body.insert(body.size(), 8'($urandom()));
                            end
                            else
                            begin
                                body.insert(body.size(), 8'($urandom_range(1, 8)));
                            end
                        end
                    end
                    2:
                    begin
                        body.insert(body.size(), dop_pkg::CODE_ADDR);
                        len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : 4;
                        body.insert(body.size(), 8'(len));
                        repeat (len) body.insert(body.size(), 8'($urandom()));
                    end
                    4:
                    begin
                        body.insert(body.size(), 8'($urandom_range(1, 254)));
                        len = $urandom_range(0, 5);
                        body.insert(body.size(), 8'(len));
                        repeat (len) body.insert(body.size(), 8'($urandom()));
                    end
                    default:
                    begin
                        body.insert(body.size(), dop_pkg::CODE_NAME);
                        len = $urandom_range(0, 8);
                        body.insert(body.size(), 8'(len));
                        repeat (len) body.insert(body.size(), 8'($urandom()));
                    end
                endcase
            end
        end
        ending = $urandom_range(0, 9);
        garbage = 0;
        if (ending < 6)
        begin
            body.insert(body.size(), dop_pkg::CODE_END);
            garbage = $urandom_range(0, 2);
        end
        else if (ending == 9)
        begin
            // Cut the packet off somewhere inside its options.
            cut = $urandom_range(0, body.size());
            while (body.size() > cut) void'(body.pop_back());
        end
        if (body.size() == 0)
        begin
            body.insert(body.size(), 8'($urandom()));
        end
        repeat (garbage) body.insert(body.size(), 8'($urandom()));
        random_count += body.size();
        // Now and then the packet is left open and the next one abandons it.
        closed = ($urandom_range(0, 11) != 0);
        foreach (body[i])
        begin
            add_byte(body[i], i == 0, closed && (i == body.size() - 1), addr);
        end
    endtask

    // Driver: offers the next pending item at the falling edge.
    always @(posedge clk)
    begin
        if (rst_n && push && !full)
        begin
            predict_options_byte(offered);
            bytes_taken++;
            byte_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!push || byte_taken))
        begin
            byte_taken = 1'b0;
            if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= idle_percent(1'b0))
            begin
                offered = pending_bytes.pop_front();
                data_byte   <= offered.data;
                first_byte  <= offered.first;
                last_byte   <= offered.last;
                client_addr <= offered.addr;
                push        <= 1'b1;
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // Monitor: checks each accepted item against the oldest expectation.
    always @(posedge clk)
    begin
        parse_result_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected item, kind %0d", kind));
            end
            else
            begin
                want = expected_results.pop_front();
                if (kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
                if (name_byte !== want.name_byte)
                    report_mismatch($sformatf("name_byte %h, expected %h",
                                              name_byte, want.name_byte));
                if (name_start !== want.name_start)
                    report_mismatch($sformatf("name_start %0d, expected %0d",
                                              name_start, want.name_start));
                if (dhcp_type !== want.dhcp_type)
                    report_mismatch($sformatf("dhcp_type %0d, expected %0d",
                                              dhcp_type, want.dhcp_type));
                if (wanted_addr !== want.wanted_addr)
                    report_mismatch($sformatf("wanted_addr %h, expected %h",
                                              wanted_addr, want.wanted_addr));
                if (status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
                if (run_end !== want.run_end)
                    report_mismatch($sformatf("run_end %0d, expected %0d", run_end, want.run_end));
            end
        end
    end

    // The receiver holds off once for a long stretch so the block fills and stalls its input.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && bytes_taken >= 150)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= ($urandom_range(0, 99) >= idle_percent(1'b1));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        // Bytes before any packet start parse with a client address of zero.
        add_byte(dop_pkg::CODE_TYPE, 1'b0, 1'b0, 32'hffff_ffff);
        add_byte(8'd1, 1'b0, 1'b0, 32'hffff_ffff);
        add_byte(8'd3, 1'b0, 1'b0, 32'hffff_ffff);
        add_byte(dop_pkg::CODE_END, 1'b0, 1'b0, 32'hffff_ffff);
        // Pad, hostname extremes, full address, empty option, then an invalid type.
        add_byte(dop_pkg::CODE_PAD, 1'b1, 1'b0, 32'hffff_ffff);
        add_byte(dop_pkg::CODE_NAME, 1'b0, 1'b0, 32'h0);
        add_byte(8'd2, 1'b0, 1'b0, 32'h0);
        add_byte(8'h00, 1'b0, 1'b0, 32'h0);
        add_byte(8'hff, 1'b0, 1'b0, 32'h0);
        add_byte(dop_pkg::CODE_ADDR, 1'b0, 1'b0, 32'h0);
        add_byte(8'd4, 1'b0, 1'b0, 32'h0);
        add_byte(8'h12, 1'b0, 1'b0, 32'h0);
        add_byte(8'h34, 1'b0, 1'b0, 32'h0);
        add_byte(8'h56, 1'b0, 1'b0, 32'h0);
        add_byte(8'h78, 1'b0, 1'b0, 32'h0);
        add_byte(dop_pkg::CODE_TYPE, 1'b0, 1'b0, 32'h0);
        add_byte(8'd0, 1'b0, 1'b0, 32'h0);
        add_byte(dop_pkg::CODE_TYPE, 1'b0, 1'b0, 32'h0);
        add_byte(8'd1, 1'b0, 1'b0, 32'h0);
        add_byte(8'd9, 1'b0, 1'b0, 32'h0);
        // Ignored: parsing has stopped.
        add_byte(8'h11, 1'b0, 1'b1, 32'h0);
        // One-byte packet cut off after its option code.
        add_byte(8'h07, 1'b1, 1'b1, 32'h0);
        // Highest valid message type ends the packet on its last byte.
        add_byte(dop_pkg::CODE_TYPE, 1'b1, 1'b0, 32'ha5a5_a5a5);
        add_byte(8'd1, 1'b0, 1'b0, 32'h0);
        add_byte(dop_pkg::TYPE_MAX, 1'b0, 1'b1, 32'h0);
        while (random_count < RANDOM_BYTES)
        begin
            queue_random_packet();
        end
        third_len = pending_bytes.size() / 3;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        do
        begin
            @(posedge clk);
        end
        while (pending_bytes.size() != 0 || push || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
